[rtl/sbtp_pkg.sv]
// Shared types, constants and helper functions for the smooth Bezier block.
package sbtp_pkg;

  localparam int CoordWidth = 24;
  localparam int FracBits   = 8;
  localparam int EpsWidth   = 8;
  // Squared sum of two coordinate differences, with headroom for the carry.
  localparam int SqWidth    = 2 * CoordWidth + 2;
  localparam int DistWidth  = CoordWidth + 1;
  localparam int RatioBits  = 16;
  localparam int RatioWidth = RatioBits + 1;
  localparam int TotWidth   = DistWidth + 1;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrZeroLen  = 2'd1;
  localparam logic [1:0] ErrOnePoint = 2'd2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t     point_x;
    coord_t     point_y;
    coord_t     edge_ctrl_x;
    coord_t     edge_ctrl_y;
    logic       is_first;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    coord_t     seg_start_x;
    coord_t     seg_start_y;
    coord_t     ctrl_a_x;
    coord_t     ctrl_a_y;
    coord_t     ctrl_b_x;
    coord_t     ctrl_b_y;
    coord_t     seg_end_x;
    coord_t     seg_end_y;
    logic       last_segment;
    logic [1:0] error_code;
  } out_item_t;

  // Start and done handshake between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  // Saturate a value two bits wider than a coordinate.
  function automatic coord_t sat_coord(input logic signed [CoordWidth+1:0] v);
    logic signed [CoordWidth+1:0] hi;
    logic signed [CoordWidth+1:0] lo;
    coord_t res;
    hi = (CoordWidth+2)'(2 ** (CoordWidth - 1) - 1);
    lo = -(CoordWidth+2)'(2 ** (CoordWidth - 1));
    if (v > hi) res = coord_t'(hi);
    else if (v < lo) res = coord_t'(lo);
    else res = coord_t'(v);
    return res;
  endfunction

  // Reflection 2*c - p, saturated.
  function automatic coord_t mirror(input coord_t p, input coord_t c);
    logic signed [CoordWidth+1:0] v;
    v = ((CoordWidth+2)'(c) <<< 1) - (CoordWidth+2)'(p);
    return sat_coord(v);
  endfunction

endpackage

[rtl/sbtp_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module sbtp_sqrt import sbtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SqWidth-1:0]    radicand,
  output logic                  done,
  output logic [DistWidth-1:0]  root
);
  localparam int Steps = SqWidth / 2;
  localparam int CntW  = $clog2(Steps + 1);

  logic [SqWidth-1:0]   rad_r, rad_nxt;
  logic [DistWidth+2:0] rem_r, rem_nxt;
  logic [DistWidth-1:0] root_r, root_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DistWidth+2:0] trial;
  logic [DistWidth+2:0] shifted;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DistWidth:0], rad_r[SqWidth-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CntW'(Steps);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[DistWidth-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[DistWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("sqrt done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("sqrt busy with zero count");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("sqrt done without work");
endmodule

[rtl/sbtp_div.sv]
// Restoring divider, one quotient bit per cycle, for the Q1.16 split ratio.
module sbtp_div import sbtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TotWidth+RatioBits-1:0] dividend,
  input  logic [TotWidth-1:0]   divisor,
  output logic                  done,
  output logic [RatioWidth-1:0] quotient
);
  localparam int NumW = TotWidth + RatioBits;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0]     num_r, num_nxt;
  logic [TotWidth:0]   rem_r, rem_nxt;
  logic [TotWidth-1:0] den_r, den_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [TotWidth:0]   shifted;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[TotWidth-1:0], num_r[NumW-1]};
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        num_nxt = {num_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  // The ratio never exceeds one, so the low bits hold the whole quotient.
  assign quotient = num_r[RatioWidth-1:0];

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("divider done without work");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider busy with zero count");
endmodule

[rtl/sbtp_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle, rounded offset out.
module sbtp_mul import sbtp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CoordWidth:0]    mcand,
  input  logic [RatioWidth-1:0]  mplier,
  output logic                   done,
  output logic [CoordWidth:0]    offset
);
  localparam int ProdW = CoordWidth + 1 + RatioWidth;
  localparam int CntW  = $clog2(RatioWidth + 1);

  logic [ProdW-1:0]      acc_r, acc_nxt;
  logic [ProdW-1:0]      mc_r, mc_nxt;
  logic [RatioWidth-1:0] mp_r, mp_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [ProdW-1:0]      rounded;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = ProdW'(mcand);
      mp_nxt   = mplier;
      cnt_nxt  = CntW'(RatioWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = mc_r << 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  // Divide by 2^17 with the half rounded up.
  assign rounded = (acc_r >> (RatioBits + 1)) + ProdW'(acc_r[RatioBits]);
  assign offset  = rounded[CoordWidth:0];
  assign done    = done_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("multiplier done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("multiplier done without work");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("multiplier busy with zero count");
endmodule

[rtl/smooth_bezier_through_points.sv]
// Top level: point window, sequencer and result queue of the smooth Bezier block.
//
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_stall   in_item_t (point, edge control, flags)
//  out      output     out_valid/out_stall out_item_t (one cubic segment)
//  cfg      input      cfg_we              cfg_wdata (coincidence epsilon)
//
// A point that closes a window of three shows its first result after two
// serial square roots, a divide and four multiplies run one after another
// on the shared units. A zero total length skips the divide and the
// multiplies. A point that gives no segment frees the input at once; one
// that gives a direct segment shows it on the next cycle. Reset is
// synchronous, active low, and clears the window, the count of points seen
// and the epsilon (to one). A stall on the output holds the result in its
// register; the block takes no new transfer until every result of the
// current point has gone out.
module smooth_bezier_through_points import sbtp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [EpsWidth-1:0] cfg_wdata
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq1  = 4'd1;
  localparam logic [3:0] StSq2  = 4'd2;
  localparam logic [3:0] StDiv  = 4'd3;
  localparam logic [3:0] StM1x  = 4'd4;
  localparam logic [3:0] StM1y  = 4'd5;
  localparam logic [3:0] StM2x  = 4'd6;
  localparam logic [3:0] StM2y  = 4'd7;
  localparam logic [3:0] StOut1 = 4'd9;
  localparam logic [3:0] StOut2 = 4'd10;

  localparam int ShiftK = (CoordWidth > 30) ? CoordWidth - 30 : 0;

  logic [3:0]          state_r, state_nxt;
  logic [EpsWidth-1:0] eps_r;
  coord_t              ax_r, ay_r, bx_r, by_r;
  coord_t              pcx_r, pcy_r;
  logic [1:0]          seen_r;
  in_item_t            cur_r;
  logic [DistWidth-1:0] d1_r;
  logic [RatioWidth-1:0] s_r;
  logic [CoordWidth:0] o1x_r, o1y_r, o2x_r;
  out_item_t           res1_r, res2_r;
  logic                two_r;
  logic                ovalid_r;

  logic                accept;
  unit_ctl_t           sq_ctl, dv_ctl, ml_ctl;
  logic [SqWidth-1:0]  sq_in;
  logic [DistWidth-1:0] sq_root;
  logic [TotWidth-1:0] tot;
  logic [RatioWidth-1:0] dv_q;
  logic [CoordWidth:0] ml_a, ml_off;
  logic [RatioWidth-1:0] ml_b;

  // Distance operands depend on which square root is being started.
  logic signed [CoordWidth:0] dx, dy, hx, hy;
  logic [CoordWidth:0]        mx, my, hmx, hmy;
  logic                       coincide;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != StIdle);

  always_comb begin
    if (state_r == StIdle) begin
      dx = (CoordWidth+1)'(ax_r) - (CoordWidth+1)'(bx_r);
      dy = (CoordWidth+1)'(ay_r) - (CoordWidth+1)'(by_r);
    end else begin
      dx = (CoordWidth+1)'(bx_r) - (CoordWidth+1)'(cur_r.point_x);
      dy = (CoordWidth+1)'(by_r) - (CoordWidth+1)'(cur_r.point_y);
    end
    mx = dx[CoordWidth] ? (CoordWidth+1)'(-dx) : dx;
    my = dy[CoordWidth] ? (CoordWidth+1)'(-dy) : dy;
    coincide = (mx < (CoordWidth+1)'(eps_r)) && (my < (CoordWidth+1)'(eps_r));
    hx  = (CoordWidth+1)'(cur_r.point_x) - (CoordWidth+1)'(ax_r);
    hy  = (CoordWidth+1)'(cur_r.point_y) - (CoordWidth+1)'(ay_r);
    hmx = hx[CoordWidth] ? (CoordWidth+1)'(-hx) : hx;
    hmy = hy[CoordWidth] ? (CoordWidth+1)'(-hy) : hy;
  end

  // The radicand is formed once, when the root starts; the square is a
  // start-cycle product of two magnitudes of at most 25 bits.
  logic [CoordWidth:0] smx, smy;
  assign smx   = mx >> ShiftK;
  assign smy   = my >> ShiftK;
  assign sq_in = coincide ? '0 : (SqWidth'(smx) * SqWidth'(smx) + SqWidth'(smy) * SqWidth'(smy));
  assign tot   = TotWidth'(d1_r) + TotWidth'(sq_root);

  sbtp_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_ctl.start), .radicand(sq_in),
    .done(sq_ctl.done), .root(sq_root)
  );

  sbtp_div u_div (
    .clk, .rst_n, .start(dv_ctl.start),
    .dividend({d1_r, RatioBits'(0)} + (TotWidth+RatioBits)'(tot >> 1)),
    .divisor(tot), .done(dv_ctl.done), .quotient(dv_q)
  );

  sbtp_mul u_mul (
    .clk, .rst_n, .start(ml_ctl.start), .mcand(ml_a), .mplier(ml_b),
    .done(ml_ctl.done), .offset(ml_off)
  );

  // Operands are taken in the state that starts the next multiply.
  always_comb begin
    unique case (state_r)
      StDiv:   begin ml_a = hmx; ml_b = dv_q; end
      StM1x:   begin ml_a = hmy; ml_b = s_r; end
      StM1y:   begin ml_a = hmx; ml_b = RatioWidth'(2 ** RatioBits) - s_r; end
      StM2x:   begin ml_a = hmy; ml_b = RatioWidth'(2 ** RatioBits) - s_r; end
      default: begin ml_a = hmx; ml_b = s_r; end
    endcase
  end

  // Signed control placement: B minus or plus an offset carrying the sign of C - A.
  function automatic coord_t place(input coord_t b, input logic [CoordWidth:0] off,
                                   input logic neg, input logic sub);
    logic signed [CoordWidth+1:0] so;
    so = (CoordWidth+2)'(off);
    if (neg ^ sub) so = -so;
    return sat_coord((CoordWidth+2)'(b) + so);
  endfunction

  logic   zero_tot;
  coord_t c2x, c2y, c3x, c3y;
  out_item_t seg_main, seg_tail;

  always_comb begin
    c2x = place(bx_r, o1x_r, hx[CoordWidth], 1'b1);
    c2y = place(by_r, o1y_r, hy[CoordWidth], 1'b1);
    c3x = place(bx_r, o2x_r, hx[CoordWidth], 1'b0);
    c3y = place(by_r, ml_off, hy[CoordWidth], 1'b0);
    zero_tot = (tot == '0);
    if (zero_tot) begin
      c2x = bx_r; c2y = by_r; c3x = bx_r; c3y = by_r;
    end
    seg_main = '{seg_start_x: ax_r, seg_start_y: ay_r, ctrl_a_x: pcx_r,
                 ctrl_a_y: pcy_r, ctrl_b_x: c2x, ctrl_b_y: c2y,
                 seg_end_x: bx_r, seg_end_y: by_r, last_segment: 1'b0,
                 error_code: zero_tot ? ErrZeroLen : ErrNone};
    seg_tail = '{seg_start_x: bx_r, seg_start_y: by_r, ctrl_a_x: c3x,
                 ctrl_a_y: c3y,
                 ctrl_b_x: mirror(cur_r.edge_ctrl_x, cur_r.point_x),
                 ctrl_b_y: mirror(cur_r.edge_ctrl_y, cur_r.point_y),
                 seg_end_x: cur_r.point_x, seg_end_y: cur_r.point_y,
                 last_segment: 1'b1, error_code: ErrNone};
  end

  // Direct results on points that close no window.
  out_item_t dir_a;
  logic      dir_any;
  always_comb begin
    dir_any = 1'b0;
    dir_a   = '{seg_start_x: in_data.point_x, seg_start_y: in_data.point_y,
                ctrl_a_x: in_data.point_x, ctrl_a_y: in_data.point_y,
                ctrl_b_x: in_data.point_x, ctrl_b_y: in_data.point_y,
                seg_end_x: in_data.point_x, seg_end_y: in_data.point_y,
                last_segment: 1'b1, error_code: ErrOnePoint};
    if (in_data.is_first) begin
      dir_any = in_data.is_last;
    end else if (seen_r == 2'd1 && in_data.is_last) begin
      dir_any = 1'b1;
      dir_a   = '{seg_start_x: bx_r, seg_start_y: by_r, ctrl_a_x: pcx_r,
                  ctrl_a_y: pcy_r,
                  ctrl_b_x: mirror(in_data.edge_ctrl_x, in_data.point_x),
                  ctrl_b_y: mirror(in_data.edge_ctrl_y, in_data.point_y),
                  seg_end_x: in_data.point_x, seg_end_y: in_data.point_y,
                  last_segment: 1'b1, error_code: ErrNone};
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sq_ctl.start = 1'b0;
    dv_ctl.start = 1'b0;
    ml_ctl.start = 1'b0;
    unique case (state_r)
      StIdle: if (accept) begin
        if (dir_any) state_nxt = StOut1;
        else if (!in_data.is_first && seen_r >= 2'd2) state_nxt = StSq1;
      end
      StSq1: if (sq_ctl.done) state_nxt = StSq2;
      StSq2: if (sq_ctl.done) state_nxt = StDiv;
      StDiv: if (dv_ctl.done) state_nxt = StM1x;
      StM1x: if (ml_ctl.done) state_nxt = StM1y;
      StM1y: if (ml_ctl.done) state_nxt = StM2x;
      StM2x: if (ml_ctl.done) state_nxt = StM2y;
      StM2y: if (ml_ctl.done || zero_tot) state_nxt = StOut1;
      StOut1: if (!out_stall) state_nxt = two_r ? StOut2 : StIdle;
      StOut2: if (!out_stall) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
    // Unit starts fire in the cycle in which the move into a state is decided.
    sq_ctl.start = (state_r == StIdle && state_nxt == StSq1) ||
                   (state_r == StSq1 && sq_ctl.done);
    dv_ctl.start = (state_r == StSq2 && sq_ctl.done && tot != '0);
    ml_ctl.start = (state_r == StDiv && dv_ctl.done) ||
                   ((state_r == StM1x || state_r == StM1y || state_r == StM2x) &&
                    ml_ctl.done);
    // A zero total skips the ratio work.
    if (state_r == StSq2 && sq_ctl.done && tot == '0) state_nxt = StM2y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      eps_r    <= EpsWidth'(1);
      seen_r   <= 2'd0;
      ax_r     <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0;
      pcx_r    <= '0; pcy_r <= '0;
      ovalid_r <= 1'b0;
      two_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) eps_r <= cfg_wdata;
      if (state_r == StIdle && accept) begin
        cur_r <= in_data;
        if (in_data.is_first) begin
          if (in_data.is_last) seen_r <= 2'd0;
          else begin
            seen_r <= 2'd1;
            bx_r   <= in_data.point_x; by_r <= in_data.point_y;
            pcx_r  <= mirror(in_data.edge_ctrl_x, in_data.point_x);
            pcy_r  <= mirror(in_data.edge_ctrl_y, in_data.point_y);
          end
        end else if (seen_r == 2'd1) begin
          ax_r <= bx_r; ay_r <= by_r;
          bx_r <= in_data.point_x; by_r <= in_data.point_y;
          seen_r <= in_data.is_last ? 2'd0 : 2'd2;
        end
        if (dir_any) begin
          res1_r   <= dir_a;
          two_r    <= 1'b0;
          ovalid_r <= 1'b1;
        end
      end
      if (state_r == StSq1 && sq_ctl.done) d1_r <= sq_root;
      if (state_r == StDiv && dv_ctl.done) s_r <= dv_q;
      if (state_r == StM1x && ml_ctl.done) o1x_r <= ml_off;
      if (state_r == StM1y && ml_ctl.done) o1y_r <= ml_off;
      if (state_r == StM2x && ml_ctl.done) o2x_r <= ml_off;
      if (state_r == StM2y && (ml_ctl.done || zero_tot)) begin
        res1_r   <= seg_main;
        res2_r   <= seg_tail;
        two_r    <= cur_r.is_last;
        ovalid_r <= 1'b1;
        // Slide the window and update the pending control.
        ax_r  <= bx_r; ay_r <= by_r;
        bx_r  <= cur_r.point_x; by_r <= cur_r.point_y;
        pcx_r <= c3x; pcy_r <= c3y;
        seen_r <= cur_r.is_last ? 2'd0 : 2'd3;
      end
      if (state_r == StOut1 && !out_stall) begin
        if (two_r) res1_r <= res2_r;
        else ovalid_r <= 1'b0;
      end
      if (state_r == StOut2 && !out_stall) ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = res1_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> (state_r == StOut1 || state_r == StOut2))
    else $error("result shown outside output states");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == StOut2) |-> out_data.last_segment)
    else $error("second result is not the closing segment");
  assert property (@(posedge clk) disable iff (!rst_n)
                   $onehot0({sq_ctl.start, dv_ctl.start, ml_ctl.start}))
    else $error("two serial units started together");
endmodule

[tb/testbench.sv]
// Testbench for the smooth Bezier block: directed and random point streams, scoreboard check.
`timescale 1ns / 100ps

module testbench;
  import sbtp_pkg::*;

  // Scoreboard: mirrors the block's window and pending control, and queues
  // the segments it should emit for every point that the block accepts.
  class segment_scoreboard;
    logic [7:0]         eps;
    logic signed [63:0] win_x [2];
    logic signed [63:0] win_y [2];
    logic signed [63:0] pend_x;
    logic signed [63:0] pend_y;
    int                 seen;
    out_item_t          segs_due [$];
    int                 errors;

    function new();
      eps = 8'd1;
      win_x[0] = 0;
      win_x[1] = 0;
      win_y[0] = 0;
      win_y[1] = 0;
      pend_x = 0;
      pend_y = 0;
      seen = 0;
      errors = 0;
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [63:0] v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Width 24 needs no pre-shift of the differences.
    function automatic logic [63:0] span(logic signed [63:0] ax, logic signed [63:0] ay,
                                         logic signed [63:0] bx, logic signed [63:0] by);
      logic [63:0] mx;
      logic [63:0] my;
      mx = magnitude(ax - bx);
      my = magnitude(ay - by);
      if (mx < eps && my < eps) return 0;
      return root(mx * mx + my * my);
    endfunction

    function automatic logic [63:0] round_half(logic [63:0] q);
      return (q >> 17) + ((q >> 16) & 64'd1);
    endfunction

    function automatic out_item_t make_seg(logic signed [63:0] sx, logic signed [63:0] sy,
                                           logic signed [63:0] ax, logic signed [63:0] ay,
                                           logic signed [63:0] bx, logic signed [63:0] by,
                                           logic signed [63:0] ex, logic signed [63:0] ey,
                                           logic lst, logic [1:0] err);
      out_item_t s;
      s.seg_start_x = coord_t'(sx);
      s.seg_start_y = coord_t'(sy);
      s.ctrl_a_x = coord_t'(ax);
      s.ctrl_a_y = coord_t'(ay);
      s.ctrl_b_x = coord_t'(bx);
      s.ctrl_b_y = coord_t'(by);
      s.seg_end_x = coord_t'(ex);
      s.seg_end_y = coord_t'(ey);
      s.last_segment = lst;
      s.error_code = err;
      return s;
    endfunction

    function void note_point(in_item_t it);
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] ex;
      logic signed [63:0] ey;
      logic signed [63:0] ax;
      logic signed [63:0] ay;
      logic signed [63:0] bx;
      logic signed [63:0] by;
      logic signed [63:0] hx;
      logic signed [63:0] hy;
      logic signed [63:0] bef_x;
      logic signed [63:0] bef_y;
      logic signed [63:0] aft_x;
      logic signed [63:0] aft_y;
      logic signed [63:0] o1x;
      logic signed [63:0] o1y;
      logic signed [63:0] o2x;
      logic signed [63:0] o2y;
      logic [63:0] d1;
      logic [63:0] d2;
      logic [63:0] tot;
      logic [63:0] ratio;
      logic [1:0] err;
      px = it.point_x;
      py = it.point_y;
      ex = it.edge_ctrl_x;
      ey = it.edge_ctrl_y;
      if (it.is_first) begin
        if (it.is_last) begin
          segs_due.push_back(make_seg(px, py, px, py, px, py, px, py, 1'b1, ErrOnePoint));
          seen = 0;
          return;
        end
        win_x[1] = px;
        win_y[1] = py;
        pend_x = clamp(2 * px - ex);
        pend_y = clamp(2 * py - ey);
        seen = 1;
        return;
      end
      if (seen == 0) return;
      if (seen >= 2) begin
        ax = win_x[0];
        ay = win_y[0];
        bx = win_x[1];
        by = win_y[1];
        d1 = span(ax, ay, bx, by);
        d2 = span(bx, by, px, py);
        tot = d1 + d2;
        err = ErrNone;
        if (tot == 0) begin
          // Coincident points: both controls collapse onto the middle point.
          bef_x = bx;
          bef_y = by;
          aft_x = bx;
          aft_y = by;
          err = ErrZeroLen;
        end else begin
          ratio = ((d1 << 16) + tot / 2) / tot;
          hx = px - ax;
          hy = py - ay;
          o1x = round_half(magnitude(hx) * ratio);
          o1y = round_half(magnitude(hy) * ratio);
          o2x = round_half(magnitude(hx) * (65536 - ratio));
          o2y = round_half(magnitude(hy) * (65536 - ratio));
          if (hx < 0) begin
            o1x = -o1x;
            o2x = -o2x;
          end
          if (hy < 0) begin
            o1y = -o1y;
            o2y = -o2y;
          end
          bef_x = clamp(bx - o1x);
          bef_y = clamp(by - o1y);
          aft_x = clamp(bx + o2x);
          aft_y = clamp(by + o2y);
        end
        segs_due.push_back(make_seg(ax, ay, pend_x, pend_y, bef_x, bef_y, bx, by,
                                    1'b0, err));
        pend_x = aft_x;
        pend_y = aft_y;
      end
      win_x[0] = win_x[1];
      win_y[0] = win_y[1];
      win_x[1] = px;
      win_y[1] = py;
      if (it.is_last) begin
        segs_due.push_back(make_seg(win_x[0], win_y[0], pend_x, pend_y,
                                    clamp(2 * px - ex), clamp(2 * py - ey),
                                    px, py, 1'b1, ErrNone));
        seen = 0;
      end else if (seen < 3) begin
        seen++;
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_segment(out_item_t got);
      out_item_t want;
      if (segs_due.size() == 0) begin
        report("unexpected segment", 0, 0);
        return;
      end
      want = segs_due.pop_front();
      if (got.seg_start_x !== want.seg_start_x)
        report("seg_start_x", got.seg_start_x, want.seg_start_x);
      if (got.seg_start_y !== want.seg_start_y)
        report("seg_start_y", got.seg_start_y, want.seg_start_y);
      if (got.ctrl_a_x !== want.ctrl_a_x) report("ctrl_a_x", got.ctrl_a_x, want.ctrl_a_x);
      if (got.ctrl_a_y !== want.ctrl_a_y) report("ctrl_a_y", got.ctrl_a_y, want.ctrl_a_y);
      if (got.ctrl_b_x !== want.ctrl_b_x) report("ctrl_b_x", got.ctrl_b_x, want.ctrl_b_x);
      if (got.ctrl_b_y !== want.ctrl_b_y) report("ctrl_b_y", got.ctrl_b_y, want.ctrl_b_y);
      if (got.seg_end_x !== want.seg_end_x)
        report("seg_end_x", got.seg_end_x, want.seg_end_x);
      if (got.seg_end_y !== want.seg_end_y)
        report("seg_end_y", got.seg_end_y, want.seg_end_y);
      if (got.last_segment !== want.last_segment)
        report("last_segment", got.last_segment, want.last_segment);
      if (got.error_code !== want.error_code)
        report("error_code", got.error_code, want.error_code);
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  segment_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int pts_left;

  // Watchdog limit on cycles without any transfer. A window point waits on the
  // serial units in turn; the receiver may stall far longer between pops.
  localparam int QuietLimit = 20000;

  smooth_bezier_through_points dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: sample at the rising edge, change the stall at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_segment(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles > QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One point transfer: an optional idle gap first, then hold until accepted.
  // Valid stays high after the transfer so that the next point can follow at
  // once; wait_idle drops it when no point follows.
  task send_point(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_point(it);
    @(negedge clk);
  endtask

  // Leave the block idle: all segments out, then some cycles for a point
  // that was taken but gives no segment.
  task wait_idle();
    in_valid <= 1'b0;
    while (board.segs_due.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task write_eps(logic [7:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.eps = v;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(200)) - 24'sd100;
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return coord_t'($urandom_range(4000)) - 24'sd2000;
    endcase
  endfunction

  function automatic in_item_t make_point(coord_t x, coord_t y, coord_t cx, coord_t cy,
                                          logic f, logic l);
    in_item_t it;
    it.point_x = x;
    it.point_y = y;
    it.edge_ctrl_x = cx;
    it.edge_ctrl_y = cy;
    it.is_first = f;
    it.is_last = l;
    return it;
  endfunction

  // A well-formed curve of n points; clustered modes produce coincident points.
  task send_curve(int n);
    int mode;
    coord_t bx;
    coord_t by;
    mode = $urandom_range(3);
    bx = rand_coord(mode);
    by = rand_coord(mode);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) begin
        bx = bx + coord_t'($urandom_range(2)) - 24'sd1;
      end else begin
        bx = rand_coord(mode);
        by = rand_coord(mode);
      end
      send_point(make_point(bx, by, rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
                            i == 0, i == n - 1));
      pts_left--;
    end
  endtask

  task random_phase(int npts, int s_pct, int r_pct);
    int pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    pts_left = npts;
    while (pts_left > 0) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        // Stray point, possibly with no curve open, or a broken curve.
        send_point(make_point(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        pts_left--;
      end else if (pick == 1) begin
        send_curve(1);
      end else if (pick < 4) begin
        send_curve(2);
      end else begin
        send_curve($urandom_range(3, 9));
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one-point curve, two-point curve, extremes with saturation,
    // coincident middle point, restart, and a point with no open curve.
    send_point(make_point(24'sh7fffff, 24'sh800000, '0, '0, 1'b1, 1'b1));
    send_point(make_point(24'sd5, 24'sd5, '0, '0, 1'b0, 1'b0));
    send_point(make_point(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff, 1'b1, 1'b0));
    send_point(make_point(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 1'b0, 1'b1));
    send_point(make_point(24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 1'b1, 1'b0));
    send_point(make_point(24'sh7fffff, 24'sh800000, '0, '0, 1'b0, 1'b0));
    send_point(make_point(24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 1'b0, 1'b1));
    send_point(make_point(24'sd100, 24'sd100, 24'sd90, 24'sd90, 1'b1, 1'b0));
    send_point(make_point(24'sd100, 24'sd100, '0, '0, 1'b0, 1'b0));
    send_point(make_point(24'sd100, 24'sd100, 24'sd7, 24'sd7, 1'b0, 1'b1));
    send_point(make_point(24'sd0, 24'sd0, 24'sd1, 24'sd1, 1'b1, 1'b0));
    send_point(make_point(24'sd300, 24'sd50, '0, '0, 1'b0, 1'b0));
    send_point(make_point(-24'sd9, 24'sd3, '0, '0, 1'b1, 1'b0));
    send_point(make_point(24'sd40, -24'sd600, '0, '0, 1'b0, 1'b0));
    send_point(make_point(24'sd41, -24'sd599, '0, '0, 1'b0, 1'b0));
    send_point(make_point(-24'sd700, 24'sd20, 24'sd1, 24'sd2, 1'b0, 1'b1));

    write_eps(8'd0);
    random_phase(350, 23, 48);
    write_eps(8'd255);
    random_phase(350, 48, 23);
    // The sender holds off until every expected segment has come.
    wait_idle();
    write_eps(8'd17);
    random_phase(400, 0, 0);
    write_eps(8'd1);
    random_phase(350, 0, 0);

    wait_idle();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
